// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the blur checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define GB_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("blur assertion failed");

// Next-cycle implication.
`define GB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("blur assertion failed");

`endif

// File: rtl/gblur5_pkg.sv
// ----------------------------------------------------------------------------
// gblur5_pkg
// Types, kernel weights and constants of the 5x5 Gaussian blur.
// ----------------------------------------------------------------------------
`default_nettype none

package gblur5_pkg;

   localparam int DEF_MAX_WIDTH  = 2048;
   localparam int DEF_MAX_HEIGHT = 4096;
   localparam int KERNEL_SIZE    = 5;
   localparam int NUM_BANKS      = 8;
   localparam int OUT_DEPTH      = 8;

   localparam logic [11:0] RESET_FRAME_WIDTH  = 12'd640;
   localparam logic [12:0] RESET_FRAME_HEIGHT = 13'd480;
   localparam logic [7:0]  ALPHA_VALUE        = 8'hFF;
   localparam logic [2:0]  TOKEN_LIMIT        = 3'd6;

   // Division by 1000 as a multiply by ceil(2^28 / 1000) and a shift.
   localparam logic [18:0] DIV_MULT  = 19'd268436;
   localparam int          DIV_SHIFT = 28;

   localparam logic [7:0] WEIGHTS [0:4][0:4] = '{
      '{8'd3,  8'd13, 8'd22,  8'd13, 8'd3},
      '{8'd13, 8'd60, 8'd98,  8'd60, 8'd13},
      '{8'd22, 8'd98, 8'd162, 8'd98, 8'd22},
      '{8'd13, 8'd60, 8'd98,  8'd60, 8'd13},
      '{8'd3,  8'd13, 8'd22,  8'd13, 8'd3}
   };

   typedef logic [23:0] pix_type;
   typedef logic [KERNEL_SIZE-1:0][23:0] vec_type;

   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [0:0] {
      OP_PIXEL = 1'b0,
      OP_DRAIN = 1'b1
   } op_type;

endpackage

`default_nettype wire

// File: rtl/gaussian_blur_5x5_clamped.sv
// ----------------------------------------------------------------------------
// gaussian_blur_5x5_clamped
// Streaming 5x5 Gaussian blur with edge replication over eight row banks
// and a chain of five column cells.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle on both sides in steady state, while rsp_tready stays high.
// Path: a result passes the row bank read, the window cells and the four-stage
// weighted sum, and then waits in the result queue.
// A new frame's words are held off until the previous frame's last result is issued.
// Reset clears the counters and valid flags; the data registers and row banks need no clearing.
`default_nettype none

module gaussian_blur_5x5_clamped #(
   parameter int MAX_WIDTH  = gblur5_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = gblur5_pkg::DEF_MAX_HEIGHT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,  // in_red, in_green, in_blue
   input  wire logic        req_tuser,  // operation
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,  // out_red, out_green, out_blue, out_alpha
   output logic             rsp_tlast,
   input  wire logic        csr_wr_en,
   input  wire logic [0:0]  csr_index,
   input  wire logic [12:0] csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_HEIGHT + 3) + 2;
   localparam int GW = $clog2(2 * MAX_WIDTH + 4) + 1;
   localparam int NB = gblur5_pkg::NUM_BANKS;
   localparam int BW = $clog2(NB);
   localparam int K  = gblur5_pkg::KERNEL_SIZE;
   localparam int OD = gblur5_pkg::OUT_DEPTH;
   localparam int OW = $clog2(OD);

   logic [11:0] fw_ff, fw_in;
   logic [12:0] fh_ff, fh_in;
   logic [WW-1:0] uw;
   logic [RW-1:0] uh;

   always_comb begin
      fw_in = fw_ff;
      fh_in = fh_ff;
      if (csr_wr_en) begin
         case (gblur5_pkg::csr_index_type'(csr_index))
            gblur5_pkg::CSR_FRAME_WIDTH:  fw_in = csr_wdata[11:0];
            gblur5_pkg::CSR_FRAME_HEIGHT: fh_in = csr_wdata;
            default: begin
               fw_in = fw_ff;
               fh_in = fh_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= gblur5_pkg::RESET_FRAME_WIDTH;
         fh_ff <= gblur5_pkg::RESET_FRAME_HEIGHT;
      end else begin
         fw_ff <= fw_in;
         fh_ff <= fh_in;
      end
   end

   always_comb begin
      if (fw_ff == 12'd0) begin
         uw = WW'(1);
      end else if (18'(fw_ff) > 18'(MAX_WIDTH)) begin
         uw = WW'(MAX_WIDTH);
      end else begin
         uw = WW'(fw_ff);
      end
      if (fh_ff == 13'd0) begin
         uh = RW'(1);
      end else if (18'(fh_ff) > 18'(MAX_HEIGHT)) begin
         uh = RW'(MAX_HEIGHT);
      end else begin
         uh = RW'(fh_ff);
      end
   end

   // Accept side
   logic [CW-1:0] ic_ff, ic_in, oc_ff, oc_in;
   logic [RW-1:0] ir_ff, ir_in, or_ff, or_in;
   logic [GW-1:0] gap_ff, gap_in;
   logic [2:0]    tok_ff, tok_in;
   logic          wrap_ff, wrap_in;
   logic          accept, take_px, in_done, emit_acc, out_last;

   // Feed and emit side
   logic [CW-1:0] fc_ff, fc_in, ec_ff, ec_in;
   logic [RW-1:0] fr_ff, fr_in, er_ff, er_in;
   logic [1:0]    di_ff, di_in, dw_ff, dw_in;
   logic          wrv_ff, wrv_in;
   logic [BW-1:0] sel_ff [K];
   logic [BW-1:0] sel_in [K];
   logic          emit_c, last_c, issue, avail, credit_ok;
   logic [RW-1:0] rr;

   assign accept  = req_tvalid && req_tready;
   assign in_done = (ir_ff == uh);
   assign take_px = accept && (req_tuser == gblur5_pkg::OP_PIXEL) && !in_done;
   assign out_last = (or_ff == uh - RW'(1)) && ((CW+1)'(oc_ff) == (CW+1)'(uw) - (CW+1)'(1));

   always_comb begin
      if (take_px) begin
         emit_acc = (gap_ff + GW'(1)) >= ((GW'(uw) << 1) + GW'(3));
      end else begin
         emit_acc = accept && in_done;
      end
   end

   assign req_tready = !wrap_ff && (tok_ff < gblur5_pkg::TOKEN_LIMIT)
                       && ((RW+1)'(ir_ff) < (RW+1)'(fr_ff) + (RW+1)'(6));

   always_comb begin
      ic_in   = ic_ff;
      ir_in   = ir_ff;
      oc_in   = oc_ff;
      or_in   = or_ff;
      gap_in  = gap_ff + GW'(take_px) - GW'(emit_acc);
      tok_in  = tok_ff + 3'(emit_acc) - 3'(emit_c);
      wrap_in = wrap_ff && !last_c;
      if (take_px) begin
         if ((CW+1)'(ic_ff) + (CW+1)'(1) == (CW+1)'(uw)) begin
            ic_in = '0;
            ir_in = ir_ff + RW'(1);
         end else begin
            ic_in = ic_ff + CW'(1);
         end
      end
      if (emit_acc) begin
         if ((CW+1)'(oc_ff) + (CW+1)'(1) == (CW+1)'(uw)) begin
            oc_in = '0;
            or_in = or_ff + RW'(1);
         end else begin
            oc_in = oc_ff + CW'(1);
         end
         if (out_last) begin
            ic_in   = '0;
            ir_in   = '0;
            oc_in   = '0;
            or_in   = '0;
            gap_in  = '0;
            wrap_in = 1'b1;
         end
      end
      if (csr_wr_en) begin
         ic_in   = '0;
         ir_in   = '0;
         oc_in   = '0;
         or_in   = '0;
         gap_in  = '0;
         tok_in  = '0;
         wrap_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ic_ff   <= '0;
         ir_ff   <= '0;
         oc_ff   <= '0;
         or_ff   <= '0;
         gap_ff  <= '0;
         tok_ff  <= '0;
         wrap_ff <= 1'b0;
      end else begin
         ic_ff   <= ic_in;
         ir_ff   <= ir_in;
         oc_ff   <= oc_in;
         or_ff   <= or_in;
         gap_ff  <= gap_in;
         tok_ff  <= tok_in;
         wrap_ff <= wrap_in;
      end
   end

   // Row banks
   gblur5_pkg::pix_type rd_data [NB];

   for (genvar b = 0; b < NB; b++) begin : g_bank
      gblur5_ram #(
         .WIDTH (24),
         .DEPTH (MAX_WIDTH)
      ) u_bank (
         .clock   (clock),
         .wr_en   (take_px && (ir_ff[BW-1:0] == BW'(b))),
         .wr_addr (ic_ff),
         .wr_data (req_tdata),
         .rd_en   (issue),
         .rd_addr (fc_ff),
         .rd_data (rd_data[b])
      );
   end

   // Feed control
   always_comb begin
      if ((RW+1)'(fr_ff) + (RW+1)'(2) >= (RW+1)'(uh)) begin
         rr = uh - RW'(1);
      end else begin
         rr = fr_ff + RW'(2);
      end
      avail = wrap_ff || (ir_ff > rr) || ((ir_ff == rr) && (ic_ff > fc_ff));
   end

   assign last_c = emit_c && (er_ff == uh - RW'(1))
                   && ((CW+1)'(ec_ff) == (CW+1)'(uw) - (CW+1)'(1));
   assign issue  = avail && ((di_ff != 2'd3) || emit_c) && !last_c;

   always_comb begin
      logic [RW:0] rsum;
      logic [RW:0] row;
      for (int t = 0; t < K; t++) begin
         rsum = (RW+1)'(fr_ff) + (RW+1)'(t);
         if (rsum < (RW+1)'(2)) begin
            row = '0;
         end else begin
            row = rsum - (RW+1)'(2);
         end
         if (row >= (RW+1)'(uh)) begin
            row = (RW+1)'(uh) - (RW+1)'(1);
         end
         sel_in[t] = row[BW-1:0];
      end
   end

   always_comb begin
      fc_in  = fc_ff;
      fr_in  = fr_ff;
      ec_in  = ec_ff;
      er_in  = er_ff;
      di_in  = di_ff + 2'(issue) - 2'(emit_c);
      dw_in  = dw_ff + 2'(wrv_ff) - 2'(emit_c);
      wrv_in = issue;
      if (issue) begin
         if ((CW+1)'(fc_ff) + (CW+1)'(1) == (CW+1)'(uw)) begin
            fc_in = '0;
            fr_in = fr_ff + RW'(1);
         end else begin
            fc_in = fc_ff + CW'(1);
         end
      end
      if (emit_c) begin
         if ((CW+1)'(ec_ff) + (CW+1)'(1) == (CW+1)'(uw)) begin
            ec_in = '0;
            er_in = er_ff + RW'(1);
         end else begin
            ec_in = ec_ff + CW'(1);
         end
      end
      if (last_c || csr_wr_en) begin
         fc_in  = '0;
         fr_in  = '0;
         ec_in  = '0;
         er_in  = '0;
         di_in  = '0;
         dw_in  = '0;
         wrv_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fc_ff  <= '0;
         fr_ff  <= '0;
         ec_ff  <= '0;
         er_ff  <= '0;
         di_ff  <= '0;
         dw_ff  <= '0;
         wrv_ff <= 1'b0;
      end else begin
         fc_ff  <= fc_in;
         fr_ff  <= fr_in;
         ec_ff  <= ec_in;
         er_ff  <= er_in;
         di_ff  <= di_in;
         dw_ff  <= dw_in;
         wrv_ff <= wrv_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int t = 0; t < K; t++) begin
         sel_ff[t] <= sel_in[t];
      end
   end

   // Window cells
   gblur5_pkg::vec_type new_vec;
   gblur5_pkg::vec_type cell_q [K];

   always_comb begin
      for (int t = 0; t < K; t++) begin
         new_vec[t] = rd_data[sel_ff[t]];
      end
   end

   for (genvar c = 0; c < K; c++) begin : g_cell
      gblur5_cell u_cell (
         .clock (clock),
         .shift (wrv_ff),
         .d_in  ((c == 0) ? new_vec : cell_q[(c == 0) ? 0 : c - 1]),
         .q     (cell_q[c])
      );
   end

   // Weighted sum pipeline
   logic [K-1:0][K-1:0][23:0] win_a_ff, win_a_in;
   logic [16:0] rows_b_ff [K][3];
   logic [16:0] rows_b_in [K][3];
   logic [17:0] acc_c_ff [3];
   logic [17:0] acc_c_in [3];
   logic [7:0]  q_d_ff [3];
   logic [7:0]  q_d_in [3];
   logic        va_ff, vb_ff, vc_ff, vd_ff;
   logic        la_ff, lb_ff, lc_ff, ld_ff;
   logic [2:0]  csel [K];
   logic [OW:0] fcnt_ff, fcnt_in;

   always_comb begin
      logic signed [CW+2:0] pos;
      for (int dd = 0; dd < K; dd++) begin
         pos = $signed((CW+3)'(ec_ff)) + (CW+3)'(dd - 2);
         if (pos < 0) begin
            csel[dd] = 3'(ec_ff) + 3'd2;
         end else if (pos >= $signed((CW+3)'(uw))) begin
            csel[dd] = 3'((CW+3)'(ec_ff) + (CW+3)'(3) - (CW+3)'(uw));
         end else begin
            csel[dd] = 3'(4 - dd);
         end
      end
      for (int t = 0; t < K; t++) begin
         for (int dd = 0; dd < K; dd++) begin
            win_a_in[t][dd] = cell_q[csel[dd]][t];
         end
      end
   end

   always_comb begin
      for (int t = 0; t < K; t++) begin
         for (int ch = 0; ch < 3; ch++) begin
            rows_b_in[t][ch] = '0;
            for (int dd = 0; dd < K; dd++) begin
               rows_b_in[t][ch] = rows_b_in[t][ch]
                  + 17'(gblur5_pkg::WEIGHTS[t][dd]) * 17'(win_a_ff[t][dd][ch*8 +: 8]);
            end
         end
      end
      for (int ch = 0; ch < 3; ch++) begin
         acc_c_in[ch] = '0;
         for (int t = 0; t < K; t++) begin
            acc_c_in[ch] = acc_c_in[ch] + 18'(rows_b_ff[t][ch]);
         end
      end
   end

   always_comb begin
      logic [36:0] prod;
      for (int ch = 0; ch < 3; ch++) begin
         prod = 37'(acc_c_ff[ch]) * 37'(gblur5_pkg::DIV_MULT);
         q_d_in[ch] = prod[gblur5_pkg::DIV_SHIFT +: 8];
      end
   end

   assign credit_ok = ((OW+1)'(fcnt_ff) + (OW+1)'(va_ff) + (OW+1)'(vb_ff)
                       + (OW+1)'(vc_ff) + (OW+1)'(vd_ff)) < (OW+1)'(OD);
   assign emit_c = (tok_ff != 3'd0) && (dw_ff == 2'd3) && credit_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else begin
         va_ff <= emit_c;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      win_a_ff <= win_a_in;
      la_ff    <= last_c;
      lb_ff    <= la_ff;
      lc_ff    <= lb_ff;
      ld_ff    <= lc_ff;
      rows_b_ff <= rows_b_in;
      acc_c_ff  <= acc_c_in;
      q_d_ff    <= q_d_in;
   end

   // Result queue
   logic [24:0]   fifo_ff [OD];
   logic [OW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic          pop;

   assign pop = rsp_tvalid && rsp_tready;

   always_comb begin
      wp_in   = wp_ff + OW'(vd_ff);
      rp_in   = rp_ff + OW'(pop);
      fcnt_in = fcnt_ff + (OW+1)'(vd_ff) - (OW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         rp_ff   <= '0;
         fcnt_ff <= '0;
      end else begin
         wp_ff   <= wp_in;
         rp_ff   <= rp_in;
         fcnt_ff <= fcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (vd_ff) begin
         fifo_ff[wp_ff] <= {ld_ff, q_d_ff[2], q_d_ff[1], q_d_ff[0]};
      end
   end

   assign rsp_tvalid = (fcnt_ff != '0);
   assign rsp_tdata  = {gblur5_pkg::ALPHA_VALUE, fifo_ff[rp_ff][23:0]};
   assign rsp_tlast  = fifo_ff[rp_ff][24];

endmodule

`default_nettype wire

// File: rtl/gblur5_ram.sv
// ----------------------------------------------------------------------------
// gblur5_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module gblur5_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/gblur5_cell.sv
// ----------------------------------------------------------------------------
// gblur5_cell
// One window cell: holds a five-pixel column and passes it to its neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module gblur5_cell (
   input  wire logic                clock,
   input  wire logic                shift,
   input  wire gblur5_pkg::vec_type d_in,
   output gblur5_pkg::vec_type      q
);

   gblur5_pkg::vec_type vec_ff;
   gblur5_pkg::vec_type vec_in;

   always_comb begin
      vec_in = shift ? d_in : vec_ff;
   end

   always_ff @(posedge clock) begin
      vec_ff <= vec_in;
   end

   assign q = vec_ff;

endmodule

`default_nettype wire

// File: rtl/gblur5_checker.sv
// ----------------------------------------------------------------------------
// gblur5_checker
// Port-level checks of the blur result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module gblur5_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic        rsp_tlast
);

   `GB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
   `GB_ASSERT_IMPL(a_alpha, clock, reset, rsp_tvalid, rsp_tdata[31:24] == gblur5_pkg::ALPHA_VALUE)
   `GB_ASSERT_IMPL(a_chan_max, clock, reset, rsp_tvalid, (rsp_tdata[7:0] != 8'hFF) && (rsp_tdata[15:8] != 8'hFF) && (rsp_tdata[23:16] != 8'hFF))
   `GB_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)

endmodule

bind gaussian_blur_5x5_clamped gblur5_checker u_gblur5_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
